### rtl/core/pale_pkg.sv
// ----------------------------------------------------------------------------
// pale_pkg
// Shared types and codes for the packed array list engine.
// ----------------------------------------------------------------------------
package pale_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 256;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned POS_W   = 8;
   localparam int unsigned TOTAL_W = 9;

   // request codes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_GET    = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

   // get on a bad index answers all ones
   localparam logic signed [VALUE_W-1:0] VALUE_NONE = '1;

   // controller -> datapath
   typedef struct packed {
      logic start;
      logic shift_step;
      logic scan_step;
      logic get_take;
      logic load_out;
   } pale_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic range_err;
      logic shift_done;
      logic scan_done;
   } pale_stat_type;

endpackage

### rtl/core/pale_datapath.sv
// ----------------------------------------------------------------------------
// pale_datapath
// Element store, entry count, scan pointer, result and output registers.
// ----------------------------------------------------------------------------
module pale_datapath
   import pale_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT,
   parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pale_cmd_type              cmd,
   output pale_stat_type             stat,
   output logic [CW-1:0]             count,
   input  logic [OP_W-1:0]           req_type,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [INDEX_W-1:0]        req_index,
   output logic [STAT_W-1:0]         rsp_status,
   output logic signed [VALUE_W-1:0] rsp_read_value,
   output logic [POS_W-1:0]          rsp_found_position,
   output logic                      rsp_found,
   output logic [TOTAL_W-1:0]        rsp_entry_total,
   output logic                      rsp_list_empty
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned XW = (CW > TOTAL_W) ? CW : TOTAL_W;

   logic [VALUE_W-1:0] mem [CAPACITY];

   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             ptr_ff, ptr_in;
   logic [AW-1:0]             tag_ff, tag_in;
   logic                      pend_ff, pend_in;
   logic [VALUE_W-1:0]        rd_ff;
   logic [VALUE_W-1:0]        val_ff, val_in;
   logic [STAT_W-1:0]         res_status_ff, res_status_in;
   logic [VALUE_W-1:0]        res_value_ff, res_value_in;
   logic [POS_W-1:0]          res_pos_ff, res_pos_in;
   logic                      res_hit_ff, res_hit_in;
   logic [STAT_W-1:0]         out_status_ff, out_status_in;
   logic [VALUE_W-1:0]        out_value_ff, out_value_in;
   logic [POS_W-1:0]          out_pos_ff, out_pos_in;
   logic                      out_hit_ff, out_hit_in;
   logic [TOTAL_W-1:0]        out_total_ff, out_total_in;
   logic                      out_empty_ff, out_empty_in;

   logic                      we;
   logic [AW-1:0]             wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;

   logic [XW-1:0]             idx_x, idx_nx, cnt_x, tag_x;
   logic                      full, range_err, more, scan_hit;

   assign idx_x  = XW'(req_index);
   assign idx_nx = idx_x + XW'(1);
   assign cnt_x  = XW'(count_ff);
   assign tag_x  = XW'(tag_ff);

   assign full      = (count_ff == CW'(CAPACITY));
   assign range_err = (idx_x >= cnt_x);
   assign more      = (ptr_ff < count_ff);
   assign scan_hit  = pend_ff && (rd_ff == val_ff);

   assign stat.range_err  = range_err;
   assign stat.shift_done = !more && !pend_ff;
   assign stat.scan_done  = scan_hit || (!more && !pend_ff);
   assign count           = count_ff;

   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      tag_in        = tag_ff;
      pend_in       = pend_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_pos_in    = res_pos_ff;
      res_hit_in    = res_hit_ff;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_pos_in    = out_pos_ff;
      out_hit_in    = out_hit_ff;
      out_total_in  = out_total_ff;
      out_empty_in  = out_empty_ff;
      we            = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      if (cmd.start) begin
         val_in        = req_value;
         res_status_in = ST_OK;
         res_value_in  = '0;
         res_pos_in    = '0;
         res_hit_in    = 1'b0;
         pend_in       = 1'b0;
         case (req_type)
            OP_INSERT: begin
               if (full) begin
                  res_status_in = ST_FULL;
               end else begin
                  we       = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = req_value;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_DELETE: begin
               if (range_err) begin
                  res_status_in = ST_RANGE;
               end else begin
                  ptr_in = idx_nx[CW-1:0];
               end
            end
            OP_GET: begin
               if (range_err) begin
                  res_status_in = ST_RANGE;
                  res_value_in  = VALUE_NONE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_x[AW-1:0];
               end
            end
            OP_FIND: begin
               res_status_in = ST_MISSING;
               ptr_in        = '0;
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      // pipelined walk: read at ptr now, use the registered word in the next cycle
      if (cmd.shift_step || cmd.scan_step) begin
         if (more) begin
            rd_en   = 1'b1;
            rd_addr = ptr_ff[AW-1:0];
            tag_in  = ptr_ff[AW-1:0];
            ptr_in  = ptr_ff + CW'(1);
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end

      if (cmd.shift_step) begin
         if (pend_ff) begin
            we      = 1'b1;
            wr_addr = tag_ff - AW'(1);
            wr_data = rd_ff;
         end
         if (stat.shift_done) begin
            count_in = count_ff - CW'(1);
         end
      end

      if (cmd.scan_step && scan_hit) begin
         res_status_in = ST_OK;
         res_pos_in    = tag_x[POS_W-1:0];
         res_hit_in    = 1'b1;
      end

      if (cmd.get_take) begin
         res_value_in = rd_ff;
      end

      if (cmd.load_out) begin
         out_status_in = res_status_ff;
         out_value_in  = res_value_ff;
         out_pos_in    = res_pos_ff;
         out_hit_in    = res_hit_ff;
         out_total_in  = cnt_x[TOTAL_W-1:0];
         out_empty_in  = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      tag_ff        <= tag_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_pos_ff    <= res_pos_in;
      res_hit_ff    <= res_hit_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_pos_ff    <= out_pos_in;
      out_hit_ff    <= out_hit_in;
      out_total_ff  <= out_total_in;
      out_empty_ff  <= out_empty_in;
   end

   assign rsp_status         = out_status_ff;
   assign rsp_read_value     = out_value_ff;
   assign rsp_found_position = out_pos_ff;
   assign rsp_found          = out_hit_ff;
   assign rsp_entry_total    = out_total_ff;
   assign rsp_list_empty     = out_empty_ff;

endmodule

### rtl/core/pale_controller.sv
// ----------------------------------------------------------------------------
// pale_controller
// Request sequencer: dispatch, shift and scan walks, result hand-off.
// ----------------------------------------------------------------------------
module pale_controller
   import pale_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [OP_W-1:0] req_type,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output pale_cmd_type    cmd,
   input  pale_stat_type   stat
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               case (req_type)
                  OP_DELETE: state_in = stat.range_err ? S_FIN : S_SHIFT;
                  OP_GET:    state_in = stat.range_err ? S_FIN : S_READ;
                  OP_FIND:   state_in = S_SCAN;
                  default:   state_in = S_FIN;
               endcase
            end
         end
         S_READ: begin
            cmd.get_take = 1'b1;
            state_in     = S_FIN;
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_done) begin
               state_in = S_FIN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!out_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

### rtl/core/packed_array_list_engine.sv
// ----------------------------------------------------------------------------
// packed_array_list_engine
// Packed list of signed 32-bit values with insert, delete, get, find, clear.
// ----------------------------------------------------------------------------
// One request beat in, one response beat out. The list lives in a simple
// dual-port style memory (one write, one registered read per cycle), and
// that read port sets the speed: insert, clear, a refused request and an
// unknown code go from acceptance straight to the result state, get passes
// through a read state first, delete at index i moves every later entry
// down one slot per cycle, and find compares entries one per cycle from the
// front until a hit or the end of the list. One request is in flight at a
// time; the response sits in an output register, so a new request is taken
// while the previous response beat still waits on rsp_stall. The count
// starts at zero after reset; the memory needs no clearing pass because no
// entry at or above the count is ever read.
// ----------------------------------------------------------------------------
module packed_array_list_engine
   import pale_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OP_W-1:0]           req_type,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [INDEX_W-1:0]        req_index,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [STAT_W-1:0]         rsp_status,
   output logic signed [VALUE_W-1:0] rsp_read_value,
   output logic [POS_W-1:0]          rsp_found_position,
   output logic                      rsp_found,
   output logic [TOTAL_W-1:0]        rsp_entry_total,
   output logic                      rsp_list_empty
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   pale_cmd_type  cmd;
   pale_stat_type stat;
   logic [CW-1:0] count;

   // sequencer: owns the handshakes and walks the datapath through each op
   pale_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // store, count, walk pointer and the response registers
   pale_datapath #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .count              (count),
      .req_type           (req_type),
      .req_value          (req_value),
      .req_index          (req_index),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_found          (rsp_found),
      .rsp_entry_total    (rsp_entry_total),
      .rsp_list_empty     (rsp_list_empty)
   );

   // count never passes the store size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   // an accepted request always stalls the request channel in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one still in flight");

   // a hit is only ever reported with ok status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
      else $error("found flag with error status");

   // at most one of start, shift step, scan step and get take at a time
   a_one_walk: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.shift_step, cmd.scan_step, cmd.get_take}))
      else $error("conflicting datapath commands");

endmodule
